// File: hdl/wcrc_pkg.sv
// package for the word crc16 core: operation codes, crc constants,
// configuration register indexes and the shared configuration struct
// no dependencies
`timescale 1ns / 1ps

package wcrc_pkg;

    localparam int unsigned CRC_W  = 16;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 2;

    localparam logic [CRC_W-1:0] SEED_MULTI  = 16'hfff8;
    localparam logic [CRC_W-1:0] POLY_MULTI  = 16'ha517;
    localparam logic [CRC_W-1:0] SEED_NORMAL = 16'hc387;
    localparam logic [CRC_W-1:0] POLY_NORMAL = 16'hc37b;

    localparam logic [WORD_W-1:0] FIN_DATA_MASK = 32'h0000_ff00;
    localparam logic [WORD_W-1:0] FIN_HIGH_ONES = 32'hffff_0000;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ADD   = 2'd1,
        OP_FINAL = 2'd2
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE = 2'd0,
        REG_HAND = 2'd1,
        REG_RAND = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              multi;
        logic [BYTE_W-1:0] hand;
        logic [BYTE_W-1:0] rand_b;
    } t_cfg;

endpackage

// File: hdl/wcrc_cfg.sv
// configuration registers of the word crc16 core
// depends on wcrc_pkg
`timescale 1ns / 1ps

module wcrc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [wcrc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [wcrc_pkg::BYTE_W-1:0] i_cfg_data,
    output wcrc_pkg::t_cfg              o_cfg
);
    import wcrc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MODE: begin
                    r_cfg.multi <= i_cfg_data[0];
                end
                REG_HAND: begin
                    r_cfg.hand <= i_cfg_data;
                end
                REG_RAND: begin
                    r_cfg.rand_b <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/wcrc_fold.sv
// combinational fold of one 32-bit word into the reflected crc16, lsb first
// depends on wcrc_pkg
`timescale 1ns / 1ps

module wcrc_fold (
    input  logic [wcrc_pkg::CRC_W-1:0]  i_crc,
    input  logic [wcrc_pkg::WORD_W-1:0] i_word,
    input  logic                        i_multi,
    output logic [wcrc_pkg::CRC_W-1:0]  o_crc
);
    import wcrc_pkg::*;

    logic [CRC_W-1:0] poly;

    assign poly = i_multi ? POLY_MULTI : POLY_NORMAL;

    // unrolled xor network, one bit step per data bit
    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc;
        for (int i = 0; i < WORD_W; i++) begin
            if (c[0] ^ i_word[i]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// File: hdl/word_crc16_with_finalize_core.sv
// top level of the word crc16 core with finalize: input register,
// crc fold and result register; depends on wcrc_pkg, wcrc_cfg, wcrc_fold
`timescale 1ns / 1ps

// channel   direction  handshake                signals
// ------    ---------  -----------------------  ---------------------------
// in        to core    i_in_valid / o_in_ready  i_operation, i_data_word
// out       from core  o_out_valid / i_out_ready o_crc_value
// cfg       to core    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one request per cycle sustained while results are taken; a result is
// registered first in the input register, then in the crc/result register
// the crc of the previous request is the result register itself, so each
// fold reads it directly with no bypass needed
// an output stall holds the result and lets one more request wait in the
// input register; ready then drops until the result is taken
// reset loads the normal seed 0xc387 and clears mode and byte latches
module word_crc16_with_finalize_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_operation,
    input  logic [wcrc_pkg::WORD_W-1:0] i_data_word,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [wcrc_pkg::CRC_W-1:0]  o_crc_value,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [wcrc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [wcrc_pkg::BYTE_W-1:0] i_cfg_data
);
    import wcrc_pkg::*;

    // configuration registers, always ready
    t_cfg cfg;

    assign o_cfg_ready = 1'b1;

    wcrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    logic              r_a_valid;
    logic [1:0]        r_a_op;
    logic [WORD_W-1:0] r_a_data;

    // crc state, doubles as the result register
    logic              r_out_valid;
    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  n_crc;
    t_cfg              r_lat;

    logic              advance;
    logic              in_take;
    logic [WORD_W-1:0] fin_word;
    logic [WORD_W-1:0] fold_word;
    logic [CRC_W-1:0]  fold_crc;

    // stage b moves when the result slot is free or being emptied
    assign advance    = r_a_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_op   <= i_operation;
            r_a_data <= i_data_word;
        end
    end

    // finalize word: data byte plus random, shifted, top ones, plus handshake
    always_comb begin
        logic [WORD_W-1:0] sum0;
        sum0     = (r_a_data & FIN_DATA_MASK) + WORD_W'(r_lat.rand_b);
        fin_word = ((sum0 << BYTE_W) | FIN_HIGH_ONES) + WORD_W'(r_lat.hand);
    end

    assign fold_word = (t_op'(r_a_op) == OP_FINAL) ? fin_word : r_a_data;

    wcrc_fold u_fold (
        .i_crc   (r_crc),
        .i_word  (fold_word),
        .i_multi (r_lat.multi),
        .o_crc   (fold_crc)
    );

    always_comb begin
        case (t_op'(r_a_op))
            OP_START: begin
                n_crc = cfg.multi ? SEED_MULTI : SEED_NORMAL;
            end
            OP_ADD, OP_FINAL: begin
                n_crc = fold_crc;
            end
            default: begin
                // unused code leaves the crc as it is
                n_crc = r_crc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= SEED_NORMAL;
            r_lat       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_crc       <= n_crc;
                // start latches mode and bytes for later folds
                if (t_op'(r_a_op) == OP_START) begin
                    r_lat <= cfg;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc;

endmodule
